[src/telemetry_poll_responder_defines.svh]
// assertion macros for the telemetry poll responder
`ifndef TELEMETRY_POLL_RESPONDER_DEFINES_SVH
`define TELEMETRY_POLL_RESPONDER_DEFINES_SVH

`ifndef SYNTH
// property checked on clk_i, off while rst_ni is low
`define TPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tpr assertion failed");
// condition that must never be seen
`define TPR_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tpr forbidden condition");
`else
`define TPR_ASSERT(lbl, prop)
`define TPR_NEVER(lbl, cond)
`endif

`endif

[src/tpr_pkg.sv]
// constants shared by the telemetry poll responder
`default_nettype none

package tpr_pkg;

  localparam int FRAME_BYTES = 10;
  localparam int SLOT_COUNT  = 6;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int SLOT_W      = 3;
  localparam int VAL_W       = 24;
  localparam int MASK_W      = SLOT_COUNT;
  localparam int SCALE_W     = 7;
  localparam int PROD_W      = VAL_W + SCALE_W;
  localparam int REPLY_BYTES = 5;
  localparam int IDX_W       = 3;

  localparam logic [7:0]         POLL_HEADER   = 8'h01;
  localparam logic [7:0]         REPLY_HEADER  = 8'h01;
  localparam logic [SCALE_W-1:0] VOLT_SCALE    = 7'd100;
  localparam logic [MASK_W-1:0]  SERVABLE_MASK = 6'h3B;

  localparam logic [SLOT_W-1:0] SLOT_MOTOR_TEMP = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_ESC_TEMP   = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_RPM1       = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_RPM2       = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_VOLT       = 3'd5;

  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

endpackage

`default_nettype wire

[src/telemetry_poll_responder.sv]
// telemetry poll responder: frame check, round robin slot pick and reply sender
// sensor updates and receiver bytes that give no reply leave it idle and ready
// a good poll walks the slot ring one slot a cycle, then multiplies in ST_MULT
// and forms the reply in ST_FORM; the reply then goes out one byte per cycle
// while the sink is ready; no new item until the fifth byte is transferred
// asynchronous active-low reset clears control state: slot values, mask, frame
`default_nettype none
`include "telemetry_poll_responder_defines.svh"

module telemetry_poll_responder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tpr_pkg::MASK_W-1:0]   cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         op_i,
  input  wire logic [7:0]                   rx_byte_i,
  input  wire logic                         frame_end_i,
  input  wire logic [tpr_pkg::SLOT_W-1:0]   sensor_slot_i,
  input  wire logic [tpr_pkg::VAL_W-1:0]    sensor_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [7:0]                        tx_byte_o,
  output logic                              last_byte_o
);
  import tpr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MULT,
    ST_FORM,
    ST_SEND
  } state_e;

  state_e                  state_q;
  logic [MASK_W-1:0]       mask_q;
  logic [VAL_W-1:0]        slot_values_q [SLOT_COUNT];
  logic [SLOT_W-1:0]       next_slot_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [7:0]              motor_prev_q;
  logic [7:0]              esc_prev_q;
  logic [15:0]             rpm_half_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [7:0]              sum_q;
  logic                    header_ok_q;
  logic                    overlong_q;
  logic [VAL_W-1:0]        val_q;
  logic [PROD_W-1:0]       prod_q;
  logic [7:0]              hi_q;
  logic [7:0]              lo_q;
  logic [7:0]              chk_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    out_valid_q;
  logic [7:0]              tx_byte_q;
  logic                    last_q;

  logic [MASK_W-1:0]       servable;
  logic                    accept;
  logic                    good;
  logic [SLOT_W-1:0]       slot_inc;
  logic [7:0]              temp;
  logic [15:0]             rpm_half;
  logic [15:0]             volt_word;
  logic [7:0]              hi_d;
  logic [7:0]              lo_d;
  logic [IDX_W-1:0]        idx_next;
  logic [7:0]              next_byte;
  logic                    out_xfer;

  assign servable  = mask_q & SERVABLE_MASK;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign out_xfer  = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_byte_q;
  assign last_byte_o = last_q;

  assign good = !overlong_q && header_ok_q && (cnt_q == CNT_W'(FRAME_BYTES - 1))
                && (rx_byte_i == sum_q);

  assign slot_inc = (slot_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_q + 1'b1;

  // reply value forming from the registered slot value and product
  always_comb begin
    temp      = (val_q[23:16] != 8'd0) ? 8'hFF : val_q[15:8];
    rpm_half  = {1'b0, val_q[23:9]};
    volt_word = (prod_q[PROD_W-1:24] != '0) ? 16'hFFFF : prod_q[23:8];
    unique case (slot_q)
      SLOT_MOTOR_TEMP: begin
        hi_d = motor_prev_q;
        lo_d = temp;
      end
      SLOT_ESC_TEMP: begin
        hi_d = esc_prev_q;
        lo_d = temp;
      end
      SLOT_RPM1: begin
        hi_d = rpm_half[15:8];
        lo_d = rpm_half[7:0];
      end
      SLOT_RPM2: begin
        hi_d = rpm_half_q[15:8];
        lo_d = rpm_half_q[7:0];
      end
      default: begin
        hi_d = volt_word[15:8];
        lo_d = volt_word[7:0];
      end
    endcase
  end

  // byte that follows the one on the output
  always_comb begin
    idx_next = idx_q + 1'b1;
    unique case (idx_next)
      3'd1:    next_byte = {{(8 - SLOT_W){1'b0}}, slot_q};
      3'd2:    next_byte = hi_q;
      3'd3:    next_byte = lo_q;
      3'd4:    next_byte = chk_q;
      default: next_byte = REPLY_HEADER;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mask_q       <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_values_q[i] <= '0;
      end
      next_slot_q  <= '0;
      slot_q       <= '0;
      motor_prev_q <= '0;
      esc_prev_q   <= '0;
      rpm_half_q   <= '0;
      cnt_q        <= '0;
      sum_q        <= '0;
      header_ok_q  <= 1'b0;
      overlong_q   <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && op_i == OP_UPDATE) begin
            if (sensor_slot_i < SLOT_W'(SLOT_COUNT)) begin
              slot_values_q[sensor_slot_i] <= sensor_value_i;
            end
          end else if (accept && op_i == OP_RX_BYTE) begin
            if (frame_end_i) begin
              cnt_q       <= '0;
              sum_q       <= '0;
              header_ok_q <= 1'b0;
              overlong_q  <= 1'b0;
              if (good && servable != '0) begin
                slot_q  <= next_slot_q;
                state_q <= ST_SEARCH;
              end
            end else begin
              if (cnt_q == '0) begin
                header_ok_q <= (rx_byte_i == POLL_HEADER);
              end
              if (overlong_q || cnt_q >= CNT_W'(FRAME_BYTES)) begin
                overlong_q <= 1'b1;
              end else begin
                if (cnt_q < CNT_W'(FRAME_BYTES - 1)) begin
                  sum_q <= sum_q + rx_byte_i;
                end
                cnt_q <= cnt_q + 1'b1;
              end
            end
          end
        end
        ST_SEARCH: begin
          // one slot per cycle; mask was nonzero when the poll was taken
          if (servable[slot_q]) begin
            state_q <= ST_MULT;
          end else begin
            slot_q <= slot_inc;
          end
        end
        ST_MULT: begin
          val_q   <= slot_values_q[slot_q];
          prod_q  <= PROD_W'(slot_values_q[slot_q]) * PROD_W'(VOLT_SCALE);
          state_q <= ST_FORM;
        end
        ST_FORM: begin
          hi_q  <= hi_d;
          lo_q  <= lo_d;
          chk_q <= REPLY_HEADER + {{(8 - SLOT_W){1'b0}}, slot_q} + hi_d + lo_d;
          if (slot_q == SLOT_MOTOR_TEMP) begin
            motor_prev_q <= temp;
          end
          if (slot_q == SLOT_ESC_TEMP) begin
            esc_prev_q <= temp;
          end
          if (slot_q == SLOT_RPM1) begin
            rpm_half_q <= rpm_half;
          end
          next_slot_q <= slot_inc;
          idx_q       <= '0;
          tx_byte_q   <= REPLY_HEADER;
          last_q      <= 1'b0;
          out_valid_q <= 1'b1;
          state_q     <= ST_SEND;
        end
        ST_SEND: begin
          if (out_xfer) begin
            if (last_q) begin
              out_valid_q <= 1'b0;
              last_q      <= 1'b0;
              state_q     <= ST_IDLE;
            end else begin
              idx_q     <= idx_next;
              tx_byte_q <= next_byte;
              last_q    <= (idx_next == IDX_W'(REPLY_BYTES - 1));
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `TPR_ASSERT(a_last_ends_reply, out_xfer && last_q |=> !out_valid_q && in_ready_o)
  `TPR_NEVER(a_ready_while_sending, in_ready_o && out_valid_q)
  `TPR_NEVER(a_next_slot_range, next_slot_q >= SLOT_W'(SLOT_COUNT))
  `TPR_NEVER(a_count_range, cnt_q > CNT_W'(FRAME_BYTES))

endmodule

`default_nettype wire
